// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tccp_pkg.sv -----
package tccp_pkg;

	localparam int CHANNELS = 3;
	localparam int CHAN_W   = 2;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// event kinds
	localparam logic [3:0] EV_NOTE       = 4'd0;
	localparam logic [3:0] EV_SAMPLE     = 4'd1;
	localparam logic [3:0] EV_ORN_NO_ENV = 4'd2;
	localparam logic [3:0] EV_REST       = 4'd3;
	localparam logic [3:0] EV_EMPTY      = 4'd4;
	localparam logic [3:0] EV_ORN0       = 4'd5;
	localparam logic [3:0] EV_ENV_START  = 4'd6;
	localparam logic [3:0] EV_ENV_PERIOD = 4'd7;
	localparam logic [3:0] EV_PERIOD_SET = 4'd8;

	// command byte boundaries
	localparam logic [7:0] CMD_NOTE_MAX   = 8'h5f;
	localparam logic [7:0] CMD_SAMPLE_MIN = 8'h60;
	localparam logic [7:0] CMD_SAMPLE_MAX = 8'h6f;
	localparam logic [7:0] CMD_ORN_MIN    = 8'h70;
	localparam logic [7:0] CMD_ORN_MAX    = 8'h7f;
	localparam logic [7:0] CMD_REST       = 8'h80;
	localparam logic [7:0] CMD_EMPTY      = 8'h81;
	localparam logic [7:0] CMD_ORN0       = 8'h82;
	localparam logic [7:0] CMD_ENV_MAX    = 8'h8e;
	localparam logic [7:0] CMD_PERIOD_BASE = 8'ha1;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [3:0]        kind;
		logic [6:0]        value;
		logic [7:0]        env_period;
		logic              row_done;
		logic [7:0]        row_skip;
	} event_t;

	// per-channel state update
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic             set_pend;
		logic             clr_pend;
		logic [3:0]       env_type;
		logic             set_period;
		logic [7:0]       period;
	} upd_t;

	// per-channel state as read for one byte
	typedef struct packed {
		logic       pend;
		logic [3:0] env_type;
		logic [7:0] period;
	} chan_state_t;

endpackage

// ----- rtl/tccp_state.sv -----
module tccp_state
	import tccp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output chan_state_t      rd,
	input  upd_t             upd
);

	logic       pend_q   [CHANNELS];
	logic [3:0] type_q   [CHANNELS];
	logic [7:0] period_q [CHANNELS];

	// read the channel of the byte in flight
	always_comb begin
		rd.pend     = pend_q[rd_idx];
		rd.env_type = type_q[rd_idx];
		rd.period   = period_q[rd_idx];
	end

	// per-channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pend_q[i]   <= 1'b0;
				type_q[i]   <= '0;
				period_q[i] <= '0;
			end
		end else if (upd.we) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (upd.idx == IDX_W'(i)) begin
					if (upd.set_pend) begin
						pend_q[i] <= 1'b1;
						type_q[i] <= upd.env_type;
					end else if (upd.clr_pend) begin
						pend_q[i] <= 1'b0;
					end
					if (upd.set_period) begin
						period_q[i] <= upd.period;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/tccp_decode.sv -----
module tccp_decode
	import tccp_pkg::*;
(
	input  logic [CHAN_W-1:0] chan,
	input  logic [7:0]        cmd_byte,
	input  chan_state_t       st,
	output event_t            ev,
	output upd_t              upd
);

	logic [7:0] period_new;
	logic [7:0] env_val;

	assign period_new = cmd_byte - CMD_PERIOD_BASE;
	assign env_val    = cmd_byte - CMD_REST;

	// classify the byte, a pending envelope takes it as the period
	always_comb begin
		ev            = '0;
		ev.chan       = chan;
		ev.row_skip   = st.period;
		upd           = '0;
		upd.idx       = chan[IDX_W-1:0];
		upd.env_type  = env_val[3:0];
		upd.period    = period_new;
		priority if (st.pend) begin
			ev.kind       = EV_ENV_PERIOD;
			ev.value      = {3'b000, st.env_type};
			ev.env_period = cmd_byte;
			upd.clr_pend  = 1'b1;
		end else if (cmd_byte <= CMD_NOTE_MAX) begin
			ev.kind     = EV_NOTE;
			ev.value    = cmd_byte[6:0];
			ev.row_done = 1'b1;
		end else if (cmd_byte <= CMD_SAMPLE_MAX) begin
			ev.kind  = EV_SAMPLE;
			ev.value = 7'(cmd_byte - CMD_SAMPLE_MIN);
		end else if (cmd_byte <= CMD_ORN_MAX) begin
			ev.kind  = EV_ORN_NO_ENV;
			ev.value = 7'(cmd_byte - CMD_ORN_MIN);
		end else if (cmd_byte == CMD_REST) begin
			ev.kind     = EV_REST;
			ev.row_done = 1'b1;
		end else if (cmd_byte == CMD_EMPTY) begin
			ev.kind     = EV_EMPTY;
			ev.row_done = 1'b1;
		end else if (cmd_byte == CMD_ORN0) begin
			ev.kind = EV_ORN0;
		end else if (cmd_byte <= CMD_ENV_MAX) begin
			ev.kind      = EV_ENV_START;
			ev.value     = env_val[6:0];
			upd.set_pend = 1'b1;
		end else begin
			ev.kind        = EV_PERIOD_SET;
			ev.row_skip    = period_new;
			upd.set_period = 1'b1;
		end
	end

endmodule

// ----- rtl/tracker_channel_command_parser.sv -----
// Channel command parser for a packed three-channel tracker pattern stream.
// Input stream: s_axis_tuser carries the channel number, s_axis_tdata the
// raw command or parameter byte of that channel. A byte whose channel is not
// one of the three is taken and dropped without an event.
// Output stream: one event per byte, the channel and event kind in
// m_axis_tuser, value, envelope period and row skip in m_axis_tdata, and
// m_axis_tlast high when the byte ends the channel's row.
// A byte passes one input register, then decode against the per-channel
// state into the output register. Throughput is one byte per cycle while
// the receiver does not stall; state is read and updated in the same
// cycle, so a channel's bytes may follow each other back to back.
// When the receiver stalls, the held event stays in the output register and
// one more byte waits in the input register before s_axis_tready drops.
// Reset clears both pipeline valids and all per-channel state (envelope
// pending flag, envelope type and row period).
`include "assert_macros.svh"

module tracker_channel_command_parser
	import tccp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] cmd_byte
	input  logic [CHAN_W-1:0] s_axis_tuser,  // [1:0] chan
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,  // [6:0] event_value, [14:7] env_period,
	                                         // [22:15] row_skip, [23] zero
	output logic [5:0]        m_axis_tuser,  // [1:0] out_chan, [5:2] event_kind
	output logic              m_axis_tlast   // row_done
);

	logic              v_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [7:0]        byte_s1;
	logic              v_s2;
	event_t            ev_s2;
	event_t            ev;
	upd_t              upd_raw;
	upd_t              upd;
	chan_state_t       st;
	logic              adv2;
	logic              adv1;
	logic              in_ok;

	assign adv2          = !v_s2 || m_axis_tready;
	assign adv1          = v_s1 && adv2;
	assign s_axis_tready = !v_s1 || adv2;
	assign in_ok         = s_axis_tuser < CHAN_W'(CHANNELS);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid && in_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			chan_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// per-channel state
	tccp_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (chan_s1[IDX_W-1:0]),
		.rd     (st),
		.upd    (upd)
	);

	// byte decode
	tccp_decode u_decode (
		.chan     (chan_s1),
		.cmd_byte (byte_s1),
		.st       (st),
		.ev       (ev),
		.upd      (upd_raw)
	);

	always_comb begin
		upd    = upd_raw;
		upd.we = adv1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ev_s2 <= ev;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {1'b0, ev_s2.row_skip, ev_s2.env_period, ev_s2.value};
	assign m_axis_tuser  = {ev_s2.kind, ev_s2.chan};
	assign m_axis_tlast  = ev_s2.row_done;

	// checks
	`ASSERT_CLK(a_row_done_kind, v_s2 && ev_s2.row_done |-> ev_s2.kind == EV_NOTE || ev_s2.kind == EV_REST || ev_s2.kind == EV_EMPTY, "row end on a byte that does not end a row")
	`ASSERT_CLK(a_env_type_range, v_s2 && ev_s2.kind == EV_ENV_PERIOD |-> ev_s2.value >= 7'd3 && ev_s2.value <= 7'd14, "envelope period event with a type outside 3..14")
	`ASSERT_CLK(a_chan_range, v_s2 |-> ev_s2.chan < CHAN_W'(CHANNELS), "event for a channel that does not exist")
	`ASSERT_CLK(a_env_period_kind, v_s2 && ev_s2.kind != EV_ENV_PERIOD |-> ev_s2.env_period == 8'd0, "envelope period set on another event kind")

endmodule

// ----- tb/tccp_event_checker.sv -----
`timescale 1ns / 1ps

module tccp_event_checker
	import tccp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] cmd_byte
	input  logic [CHAN_W-1:0] s_axis_tuser,  // [1:0] chan
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [23:0]       m_axis_tdata,  // [6:0] event_value, [14:7] env_period,
	                                         // [22:15] row_skip, [23] zero
	input  logic [5:0]        m_axis_tuser,  // [1:0] out_chan, [5:2] event_kind
	input  logic              m_axis_tlast,  // row_done
	output int                fail_count,
	output int                pending_events,
	output int                events_checked,
	output logic [8:0]        kinds_seen
);

	// per-channel decoder state as the predictor sees it
	logic       env_wait [CHANNELS];
	logic [3:0] env_type_kept [CHANNELS];
	logic [7:0] skip_lines [CHANNELS];

	event_t expected_events [$];
	event_t oldest;
	int     mismatches = 0;
	int     checked = 0;
	logic [8:0] seen = '0;

	assign fail_count     = mismatches;
	assign events_checked = checked;
	assign kinds_seen     = seen;

	// classify one byte of one channel and update that channel's state
	function automatic event_t decode_command(input logic [CHAN_W-1:0] ch, input logic [7:0] b);
		event_t     ev;
		logic [7:0] offs;
		ev = '0;
		ev.chan = ch;
		if (env_wait[ch]) begin
			// any byte is the envelope period while one is owed
			ev.kind       = EV_ENV_PERIOD;
			ev.value      = {3'b000, env_type_kept[ch]};
			ev.env_period = b;
			env_wait[ch]  = 1'b0;
		end else if (b <= CMD_NOTE_MAX) begin
			ev.kind     = EV_NOTE;
			ev.value    = b[6:0];
			ev.row_done = 1'b1;
		end else if (b <= CMD_SAMPLE_MAX) begin
			offs     = b - CMD_SAMPLE_MIN;
			ev.kind  = EV_SAMPLE;
			ev.value = offs[6:0];
		end else if (b <= CMD_ORN_MAX) begin
			offs     = b - CMD_ORN_MIN;
			ev.kind  = EV_ORN_NO_ENV;
			ev.value = offs[6:0];
		end else if (b == CMD_REST) begin
			ev.kind     = EV_REST;
			ev.row_done = 1'b1;
		end else if (b == CMD_EMPTY) begin
			ev.kind     = EV_EMPTY;
			ev.row_done = 1'b1;
		end else if (b == CMD_ORN0) begin
			ev.kind = EV_ORN0;
		end else if (b <= CMD_ENV_MAX) begin
			offs              = b - CMD_REST;
			ev.kind           = EV_ENV_START;
			ev.value          = offs[6:0];
			env_type_kept[ch] = offs[3:0];
			env_wait[ch]      = 1'b1;
		end else begin
			// period bytes below the base wrap around
			ev.kind        = EV_PERIOD_SET;
			skip_lines[ch] = b - CMD_PERIOD_BASE;
		end
		ev.row_skip = skip_lines[ch];
		return ev;
	endfunction

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// compare each output transfer, then predict from each input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				env_wait[i]      = 1'b0;
				env_type_kept[i] = '0;
				skip_lines[i]    = '0;
			end
			expected_events.delete();
			pending_events = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected event, expected none, actual tuser %0h tdata %0h tlast %0b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					oldest = expected_events.pop_front();
					check_field("out_chan", oldest.chan, m_axis_tuser[1:0]);
					check_field("event_kind", oldest.kind, m_axis_tuser[5:2]);
					check_field("event_value", oldest.value, m_axis_tdata[6:0]);
					check_field("env_period", oldest.env_period, m_axis_tdata[14:7]);
					check_field("row_skip", oldest.row_skip, m_axis_tdata[22:15]);
					check_field("tdata pad", 0, m_axis_tdata[23]);
					check_field("row_done", oldest.row_done, m_axis_tlast);
					checked++;
					if (oldest.kind <= EV_PERIOD_SET)
						seen[oldest.kind] = 1'b1;
				end
			end
			if (s_axis_tvalid && s_axis_tready && (s_axis_tuser < CHANNELS))
				expected_events.insert(expected_events.size(),
					decode_command(s_axis_tuser, s_axis_tdata));
			pending_events = expected_events.size();
		end
	end

endmodule

// ----- tb/tracker_channel_command_parser_test.sv -----
`timescale 1ns / 1ps

module tracker_channel_command_parser_test;
	import tccp_pkg::*;

	localparam int RANDOM_ITEMS = 1125;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 1000;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;  // [7:0] cmd_byte
	logic [CHAN_W-1:0] s_axis_tuser = '0;  // [1:0] chan
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;       // [6:0] event_value, [14:7] env_period,
	                                       // [22:15] row_skip, [23] zero
	logic [5:0]        m_axis_tuser;       // [1:0] out_chan, [5:2] event_kind
	logic              m_axis_tlast;       // row_done

	int         fail_count;
	int         pending_events;
	int         events_checked;
	logic [8:0] kinds_seen;

	bit source_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	int bytes_sent = 0;
	int bytes_dropped = 0;
	int quiet_cycles = 0;

	tracker_channel_command_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	tccp_event_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.fail_count     (fail_count),
		.pending_events (pending_events),
		.events_checked (events_checked),
		.kinds_seen     (kinds_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls in random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (sink_stalls && ($urandom_range(0, 3) == 0)) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tracker_channel_command_parser_test NOT OK");
		$finish;
	end

	// one byte transfer, then maybe a gap; called at a falling edge
	task automatic send_cmd(input logic [CHAN_W-1:0] ch, input logic [7:0] b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= ch;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		if (ch < CHANNELS)
			bytes_sent++;
		else
			bytes_dropped++;
		if (source_gaps && ($urandom_range(0, 4) == 0)) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// drop valid and hold off until every event is back
	task automatic drain_events();
		s_axis_tvalid <= 1'b0;
		while (pending_events != 0) @(negedge clk);
	endtask

	// random byte drawn per command class so every class shows up often
	function automatic logic [7:0] pick_cmd(input int unsigned cls);
		case (cls)
			0: return 8'($urandom_range(0, 'h5f));
			1: return 8'($urandom_range(CMD_SAMPLE_MIN, CMD_SAMPLE_MAX));
			2: return 8'($urandom_range(CMD_ORN_MIN, CMD_ORN_MAX));
			3: return CMD_REST;
			4: return CMD_EMPTY;
			5: return CMD_ORN0;
			6: return 8'($urandom_range(CMD_ORN0 + 1, CMD_ENV_MAX));
			7: return 8'($urandom_range(CMD_ENV_MAX + 1, CMD_PERIOD_BASE - 1));
			8: return 8'($urandom_range(CMD_PERIOD_BASE, 'hff));
			default: return 8'($urandom_range(0, 'hff));
		endcase
	endfunction

	initial begin
		logic [CHAN_W-1:0] ch;
		logic [7:0]        b;
		int                n;
		int                target;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		@(negedge clk);

		// directed: class edges, envelope hand-off, period wrap, dropped channel
		send_cmd(0, 8'h00);
		send_cmd(0, CMD_NOTE_MAX);
		send_cmd(1, CMD_SAMPLE_MIN);
		send_cmd(1, CMD_SAMPLE_MAX);
		send_cmd(2, CMD_ORN_MIN);
		send_cmd(2, CMD_ORN_MAX);
		send_cmd(0, CMD_REST);
		send_cmd(1, CMD_EMPTY);
		send_cmd(2, CMD_ORN0);
		send_cmd(0, CMD_ORN0 + 8'd1);
		send_cmd(1, CMD_ENV_MAX);
		send_cmd(0, CMD_ENV_MAX);      // taken as period, not a command
		send_cmd(1, 8'h00);
		send_cmd(2, CMD_ENV_MAX + 8'd1);
		send_cmd(2, 8'h2a);
		send_cmd(0, CMD_PERIOD_BASE - 8'd1);
		send_cmd(0, CMD_REST);
		send_cmd(1, CMD_PERIOD_BASE);
		send_cmd(1, 8'hff);
		send_cmd(1, CMD_EMPTY);
		send_cmd(3, 8'h55);
		send_cmd(2, CMD_ORN0 + 8'd1);
		send_cmd(3, CMD_ENV_MAX);      // dropped, must not eat the pending period
		send_cmd(2, 8'hff);
		send_cmd(3, 8'h00);
		drain_events();
		@(negedge clk);

		// random: mostly class-shaped bytes, envelope starts often followed by their period
		target = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < target) begin
			n = target - bytes_sent;
			if (n <= QUIET_TAIL) begin
				source_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else if ((bytes_sent % 100) == 0) begin
				source_gaps = ($urandom_range(0, 2) != 0);
				sink_stalls = ($urandom_range(0, 2) != 0);
			end
			if (bytes_sent == target - RANDOM_ITEMS / 2)
				drain_events();
			ch = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, CHANNELS - 1));
			b  = pick_cmd($urandom_range(0, 9));
			send_cmd(ch, b);
			if ((ch < CHANNELS) && (b > CMD_ORN0) && (b <= CMD_ENV_MAX) &&
			    ($urandom_range(0, 3) != 0))
				send_cmd(ch, 8'($urandom_range(0, 'hff)));
		end
		s_axis_tvalid <= 1'b0;

		// drain, then let the pipeline settle
		while (pending_events != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("sent %0d channel bytes and %0d out-of-range bytes, %0d events checked",
			bytes_sent, bytes_dropped, events_checked);
		$display("event kinds seen (kind 8 down to 0): %b", kinds_seen);
		if ((fail_count == 0) && (pending_events == 0)) begin
			$display("tracker_channel_command_parser_test OK");
		end else begin
			$display("tracker_channel_command_parser_test NOT OK");
		end
		$finish;
	end

endmodule
